/* rtl/core/double_hash_table_top_macros.svh */
// Assertion macros for the double hashing table, clocked on i_clk and quiet during reset.
`ifndef DOUBLE_HASH_TABLE_TOP_MACROS_SVH
`define DOUBLE_HASH_TABLE_TOP_MACROS_SVH

// Check a condition at every clock edge.
`define DHT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its cause.
`define DHT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define DHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/dht_pkg.sv */
// Shared widths, slot markers and operation codes of the double hashing table.
`default_nettype none

package dht_pkg;

    localparam int unsigned KEY_W          = 31;
    localparam int unsigned SLOT_W         = 32;
    localparam int unsigned PAY_W          = 64;
    localparam int unsigned CNT_OUT_W      = 5;
    localparam int unsigned TABLE_SIZE_DEF = 31;
    localparam int unsigned STEP_MOD       = 7;

    // Slot markers; a stored key has its top bit clear, so it never equals either
    localparam logic [SLOT_W-1:0] KEY_EMPTY   = 32'hFFFF_FFFF;
    localparam logic [SLOT_W-1:0] KEY_DELETED = 32'hFFFF_FFFE;

    typedef enum logic [1:0] {
        FUNC_RETRIEVE = 2'd0,
        FUNC_INSERT   = 2'd1,
        FUNC_DELETE   = 2'd2
    } t_func;

endpackage

`default_nettype wire

/* rtl/core/double_hash_table_top.sv */
// Top level of the open addressing hash table with double hashing.
//
//   channel   direction  handshake                 word
//   input     in         i_in_valid / o_in_stall   i_func, i_key, i_payload_in
//   result    out        o_out_valid / i_out_stall o_found, o_payload_out, o_entry_count,
//                                                  o_table_full, o_insert_refused
//
// After reset a clearing pass writes the empty marker into every slot, during which
// o_in_stall stays high.
// An operation forms the home slot and probe step of its key from one shared reciprocal
// multiplier, then probes slots, each probe a read of the single read port of the slot
// memory followed by a compare, and then loads its result word; the block passes through
// idle before it takes the next word. At most TABLE_SIZE slots are probed.
// An insert into a full table and an unknown operation code skip hashing and probing.
// One operation is in flight at a time; the result register frees the input side while a
// finished word waits on i_out_stall.
`default_nettype none

module double_hash_table_top #(
    parameter int unsigned TABLE_SIZE = dht_pkg::TABLE_SIZE_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [1:0]                     i_func,
    input  wire logic [dht_pkg::KEY_W-1:0]      i_key,
    input  wire logic [dht_pkg::PAY_W-1:0]      i_payload_in,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_found,
    output logic [dht_pkg::PAY_W-1:0]           o_payload_out,
    output logic [dht_pkg::CNT_OUT_W-1:0]       o_entry_count,
    output logic                                o_table_full,
    output logic                                o_insert_refused
);

    `include "double_hash_table_top_macros.svh"

    localparam int unsigned LW  = $clog2(TABLE_SIZE);
    localparam int unsigned SW  = $clog2(dht_pkg::STEP_MOD + 1);
    localparam int unsigned CW0 = $clog2(TABLE_SIZE + 1);
    localparam int unsigned CW  = (CW0 > dht_pkg::CNT_OUT_W) ? CW0 : dht_pkg::CNT_OUT_W;
    localparam logic [LW:0]   TS_L = (LW + 1)'(TABLE_SIZE);
    localparam logic [CW-1:0] TS_C = CW'(TABLE_SIZE);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_HASH  = 6'b000100,
        ST_READ  = 6'b001000,
        ST_CHECK = 6'b010000,
        ST_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [1:0]                 r_func;
    logic [dht_pkg::KEY_W-1:0]  r_key;
    logic [dht_pkg::PAY_W-1:0]  r_pay;
    logic [LW-1:0]              r_loc, n_loc;
    logic [LW-1:0]              r_start, n_start;
    logic [SW-1:0]              r_step, n_step;
    logic [LW-1:0]              r_clr, n_clr;
    logic [CW-1:0]              r_count, n_count;
    logic                       r_found, n_found;
    logic [dht_pkg::PAY_W-1:0]  r_pout, n_pout;
    logic                       r_refused, n_refused;

    logic [dht_pkg::SLOT_W-1:0] r_mem_key [TABLE_SIZE];
    logic [dht_pkg::PAY_W-1:0]  r_mem_pay [TABLE_SIZE];
    logic [dht_pkg::SLOT_W-1:0] r_rd_key;
    logic [dht_pkg::PAY_W-1:0]  r_rd_pay;

    logic                       r_out_valid;
    logic                       r_out_found;
    logic [dht_pkg::PAY_W-1:0]  r_out_pay;
    logic [CW-1:0]              r_out_count;
    logic                       r_out_refused;

    logic                       w_accept;
    logic                       w_hash_start;
    logic                       w_hash_done;
    logic [LW-1:0]              w_home;
    logic [SW-1:0]              w_step;
    logic                       w_rd_en;
    logic                       w_wr_key_en;
    logic                       w_wr_pay_en;
    logic [LW-1:0]              w_wr_addr;
    logic [dht_pkg::SLOT_W-1:0] w_wr_key;
    logic                       w_load;
    logic [dht_pkg::SLOT_W-1:0] w_key_ext;
    logic                       w_is_key;
    logic                       w_is_empty;
    logic                       w_is_del;
    logic [LW:0]                w_sum;
    logic [LW-1:0]              w_next;
    logic                       w_wrap;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    dht_hash #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hash_start),
        .i_key   (i_key),
        .o_done  (w_hash_done),
        .o_home  (w_home),
        .o_step  (w_step)
    );

    // Classify the slot just read and work out the next slot on the probe sequence
    always_comb begin
        w_key_ext  = {1'b0, r_key};
        w_is_key   = (r_rd_key == w_key_ext);
        w_is_empty = (r_rd_key == dht_pkg::KEY_EMPTY);
        w_is_del   = (r_rd_key == dht_pkg::KEY_DELETED);
        w_sum      = {1'b0, r_loc} + (LW + 1)'(r_step);
        w_next     = (w_sum >= TS_L) ? LW'(w_sum - TS_L) : LW'(w_sum);
        w_wrap     = (w_next == r_start);
    end

    // Sequence the clearing pass, hashing, probing and result hand-off
    always_comb begin
        n_state      = r_state;
        n_loc        = r_loc;
        n_start      = r_start;
        n_step       = r_step;
        n_clr        = r_clr;
        n_count      = r_count;
        n_found      = r_found;
        n_pout       = r_pout;
        n_refused    = r_refused;
        w_hash_start = 1'b0;
        w_rd_en      = 1'b0;
        w_wr_key_en  = 1'b0;
        w_wr_pay_en  = 1'b0;
        w_wr_addr    = r_loc;
        w_wr_key     = dht_pkg::KEY_DELETED;
        w_load       = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                w_wr_key_en = 1'b1;
                w_wr_addr   = r_clr;
                w_wr_key    = dht_pkg::KEY_EMPTY;
                n_clr       = r_clr + LW'(1);
                if (r_clr == LW'(TABLE_SIZE - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_found   = 1'b0;
                    n_pout    = '0;
                    n_refused = 1'b0;
                    if (!(i_func inside {dht_pkg::FUNC_RETRIEVE, dht_pkg::FUNC_INSERT,
                                         dht_pkg::FUNC_DELETE})) begin
                        n_state = ST_DONE;
                    end else if ((i_func == dht_pkg::FUNC_INSERT) && (r_count >= TS_C)) begin
                        n_refused = 1'b1;
                        n_state   = ST_DONE;
                    end else begin
                        w_hash_start = 1'b1;
                        n_state      = ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                if (w_hash_done) begin
                    n_loc   = w_home;
                    n_start = w_home;
                    n_step  = w_step;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                w_rd_en = 1'b1;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = ST_DONE;
                case (r_func)
                    dht_pkg::FUNC_INSERT: begin
                        if (w_is_empty || w_is_del) begin
                            w_wr_key_en = 1'b1;
                            w_wr_pay_en = 1'b1;
                            w_wr_key    = w_key_ext;
                            n_count     = r_count + CW'(1);
                        end else if (w_wrap) begin
                            n_refused = 1'b1;
                        end else begin
                            n_loc   = w_next;
                            n_state = ST_READ;
                        end
                    end
                    dht_pkg::FUNC_RETRIEVE, dht_pkg::FUNC_DELETE: begin
                        if (w_is_key) begin
                            n_found = 1'b1;
                            if (r_func == dht_pkg::FUNC_RETRIEVE) begin
                                n_pout = r_rd_pay;
                            end else begin
                                w_wr_key_en = 1'b1;
                                if (r_count != '0) begin
                                    n_count = r_count - CW'(1);
                                end
                            end
                        end else if (!w_is_empty && !w_wrap) begin
                            n_loc   = w_next;
                            n_state = ST_READ;
                        end
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the operation word and the probe position
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_func;
            r_key  <= i_key;
            r_pay  <= i_payload_in;
        end
        r_loc     <= n_loc;
        r_start   <= n_start;
        r_step    <= n_step;
        r_found   <= n_found;
        r_pout    <= n_pout;
        r_refused <= n_refused;
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_key_en) begin
            r_mem_key[w_wr_addr] <= w_wr_key;
        end
        if (w_wr_pay_en) begin
            r_mem_pay[w_wr_addr] <= r_pay;
        end
        if (w_rd_en) begin
            r_rd_key <= r_mem_key[r_loc];
            r_rd_pay <= r_mem_pay[r_loc];
        end
    end

    // Load the result word when the output register is free or draining
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_found   <= r_found;
            r_out_pay     <= r_pout;
            r_out_count   <= r_count;
            r_out_refused <= r_refused;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_found          = r_out_found;
    assign o_payload_out    = r_out_pay;
    assign o_entry_count    = r_out_count[dht_pkg::CNT_OUT_W-1:0];
    assign o_table_full     = (r_out_count == TS_C);
    assign o_insert_refused = r_out_refused;

    `DHT_ASSERT_ALWAYS(a_count_bound, r_count <= TS_C, "occupied count above table size")
    `DHT_ASSERT_IMPLIES(a_hash_in_phase, w_hash_done, r_state == ST_HASH, "hash out of phase")
    `DHT_ASSERT_NEXT(a_accept_path, w_accept,
        (r_state == ST_HASH) || (r_state == ST_DONE), "bad state after accept")
    `DHT_ASSERT_IMPLIES(a_refuse_no_hit, o_out_valid, !(o_found && o_insert_refused), "refused word marked found")

endmodule

`default_nettype wire

/* rtl/core/dht_hash.sv */
// Reciprocal multiplier unit that forms the home slot and probe step of a key.
`default_nettype none

module dht_hash #(
    parameter int unsigned TABLE_SIZE = dht_pkg::TABLE_SIZE_DEF,
    localparam int unsigned LW = $clog2(TABLE_SIZE),
    localparam int unsigned SW = $clog2(dht_pkg::STEP_MOD + 1)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [dht_pkg::KEY_W-1:0]  i_key,
    output logic                            o_done,
    output logic [LW-1:0]                   o_home,
    output logic [SW-1:0]                   o_step
);

    // Quotients come from key * ceil(2^s / m) >> s, exact for every 31-bit key
    // when s = key width + ceil(log2 m); both reciprocals fit in 32 bits
    localparam int unsigned KW   = dht_pkg::KEY_W;
    localparam int unsigned RW   = 32;
    localparam int unsigned PW   = KW + RW;
    localparam int unsigned SH_T = KW + LW;
    localparam int unsigned SH_S = KW + $clog2(dht_pkg::STEP_MOD);
    localparam logic [RW-1:0] RCP_T =
        RW'(((64'd1 << SH_T) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));
    localparam logic [RW-1:0] RCP_S =
        RW'(((64'd1 << SH_S) + 64'(dht_pkg::STEP_MOD) - 64'd1) / 64'(dht_pkg::STEP_MOD));
    localparam logic [KW-1:0] TS_K  = KW'(TABLE_SIZE);
    localparam logic [KW-1:0] MOD_K = KW'(dht_pkg::STEP_MOD);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_HOME = 4'b0010,
        PH_STEP = 4'b0100,
        PH_FIN  = 4'b1000
    } t_phase;

    t_phase          r_phase;
    logic            r_done;
    logic [KW-1:0]   r_key;
    logic [KW-1:0]   r_quo;
    logic [LW-1:0]   r_home;
    logic [SW-1:0]   r_step;

    logic [RW-1:0]   w_rcp;
    logic [PW-1:0]   w_prod;
    logic [KW-1:0]   w_quo;
    logic [KW-1:0]   w_rem_t;
    logic [KW-1:0]   w_rem_s;

    // Share one multiplier between both quotients; fold each back into a remainder
    always_comb begin
        w_rcp   = (r_phase == PH_HOME) ? RCP_T : RCP_S;
        w_prod  = PW'(r_key) * PW'(w_rcp);
        w_quo   = (r_phase == PH_HOME) ? KW'(w_prod >> SH_T) : KW'(w_prod >> SH_S);
        w_rem_t = r_key - (r_quo * TS_K);
        w_rem_s = r_key - (r_quo * MOD_K);
    end

    // Step through table quotient, step quotient and final remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_phase <= PH_HOME;
                    end
                end
                PH_HOME: begin
                    r_phase <= PH_STEP;
                end
                PH_STEP: begin
                    r_phase <= PH_FIN;
                end
                PH_FIN: begin
                    r_phase <= PH_IDLE;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    // Hold the key, the running quotient and both results
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
        end
        if ((r_phase == PH_HOME) || (r_phase == PH_STEP)) begin
            r_quo <= w_quo;
        end
        if (r_phase == PH_STEP) begin
            r_home <= LW'(w_rem_t);
        end
        if (r_phase == PH_FIN) begin
            r_step <= SW'(dht_pkg::STEP_MOD) - SW'(w_rem_s);
        end
    end

    assign o_done = r_done;
    assign o_home = r_home;
    assign o_step = r_step;

endmodule

`default_nettype wire

/* bench/double_hash_table_top_tb.sv */
// Self-checking testbench of the double hashing table: queued words, predictor, checks.
`timescale 1ns / 100ps

module double_hash_table_top_tb;

    localparam int unsigned SLOTS      = dht_pkg::TABLE_SIZE_DEF;
    localparam int unsigned KW         = dht_pkg::KEY_W;
    localparam int unsigned PW         = dht_pkg::PAY_W;
    localparam int unsigned CW         = dht_pkg::CNT_OUT_W;
    localparam int unsigned SLW        = dht_pkg::SLOT_W;
    localparam logic [1:0]  FUNC_NOP   = 2'd3;
    localparam int          IDLE_LIMIT = 4000;
    localparam int          TAIL_OPS   = 150;
    localparam int          RAND_OPS   = 1850;
    localparam int          POOL_KEYS  = 40;
    localparam int          MODE_FILL  = 0;
    localparam int          MODE_DRAIN = 1;
    localparam int          MODE_MIXED = 2;

    typedef struct {
        logic [1:0]    func;
        logic [KW-1:0] key;
        logic [PW-1:0] payload;
        int            gap;
        int            hold_pct;
        bit            drain;
    } t_table_op;

    typedef struct {
        logic          found;
        logic [PW-1:0] payload;
        logic [CW-1:0] count;
        logic          full;
        logic          refused;
    } t_table_answer;

    logic                 i_clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic [1:0]           func;
    logic [KW-1:0]        key;
    logic [PW-1:0]        payload_in;
    logic                 out_stall;
    logic                 in_stall;
    logic                 out_valid;
    logic                 found;
    logic [PW-1:0]        payload_out;
    logic [CW-1:0]        entry_count;
    logic                 table_full;
    logic                 insert_refused;

    // Predicted table contents
    logic [SLW-1:0]       shadow_key [SLOTS];
    logic [PW-1:0]        shadow_pay [SLOTS];
    int unsigned          shadow_count;

    t_table_op            queued_ops[$];
    t_table_answer        table_answers[$];

    int                   errors = 0;
    int                   ops_sent = 0;
    int                   answers_seen = 0;
    int                   gap_left = 0;
    bit                   head_loaded = 1'b0;
    int                   hold_pct = 0;
    int                   stall_left = 0;
    int                   idle_cycles = 0;

    double_hash_table_top #(.TABLE_SIZE(SLOTS)) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_func          (func),
        .i_key           (key),
        .i_payload_in    (payload_in),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_found         (found),
        .o_payload_out   (payload_out),
        .o_entry_count   (entry_count),
        .o_table_full    (table_full),
        .o_insert_refused(insert_refused)
    );

    always #1 i_clk = ~i_clk;

    // Walk the probe sequence of a key; give its slot when it is present
    function automatic bit locate_key(input logic [SLW-1:0] k, output int where);
        int unsigned home;
        int unsigned step;
        int unsigned pos;
        int unsigned n;
        home  = k % SLOTS;
        step  = dht_pkg::STEP_MOD - (k % dht_pkg::STEP_MOD);
        pos   = home;
        where = 0;
        for (n = 0; n < SLOTS; n++) begin
            if (shadow_key[pos] == k) begin
                where = pos;
                return 1'b1;
            end
            if (shadow_key[pos] == dht_pkg::KEY_EMPTY)
                return 1'b0;
            pos = (pos + step) % SLOTS;
            if (pos == home)
                return 1'b0;
        end
        return 1'b0;
    endfunction

    // Apply one operation to the predicted table and queue the answer it gives
    function automatic void apply_table_op(input logic [1:0] f, input logic [KW-1:0] k,
                                           input logic [PW-1:0] p);
        t_table_answer ans;
        logic [SLW-1:0] wide_key;
        int where;
        int unsigned step;
        int unsigned pos;
        int unsigned n;
        bit placed;
        ans      = '{default: '0};
        wide_key = {1'b0, k};
        placed   = 1'b0;
        case (f)
            dht_pkg::FUNC_RETRIEVE: begin
                if (locate_key(wide_key, where)) begin
                    ans.found   = 1'b1;
                    ans.payload = shadow_pay[where];
                end
            end
            dht_pkg::FUNC_INSERT: begin
                if (shadow_count < SLOTS) begin
                    step = dht_pkg::STEP_MOD - (wide_key % dht_pkg::STEP_MOD);
                    pos  = wide_key % SLOTS;
                    for (n = 0; n < SLOTS && !placed; n++) begin
                        if (shadow_key[pos] == dht_pkg::KEY_EMPTY
                            || shadow_key[pos] == dht_pkg::KEY_DELETED) begin
                            shadow_key[pos] = wide_key;
                            shadow_pay[pos] = p;
                            shadow_count++;
                            placed = 1'b1;
                        end else begin
                            pos = (pos + step) % SLOTS;
                        end
                    end
                end
                ans.refused = !placed;
            end
            dht_pkg::FUNC_DELETE: begin
                if (locate_key(wide_key, where)) begin
                    ans.found         = 1'b1;
                    shadow_key[where] = dht_pkg::KEY_DELETED;
                    shadow_pay[where] = '0;
                    if (shadow_count > 0)
                        shadow_count--;
                end
            end
            default: ;
        endcase
        ans.count = shadow_count[CW-1:0];
        ans.full  = (shadow_count == SLOTS);
        table_answers.push_back(ans);
    endfunction

    function automatic void queue_op(input logic [1:0] f, input logic [KW-1:0] k,
                                     input logic [PW-1:0] p, input int gap,
                                     input int pct, input bit drain);
        t_table_op op;
        op.func     = f;
        op.key      = k;
        op.payload  = p;
        op.gap      = gap;
        op.hold_pct = pct;
        op.drain    = drain;
        queued_ops.push_back(op);
    endfunction

    function automatic int random_gap(input int pct);
        if ($urandom_range(0, 99) < pct)
            return $urandom_range(1, 19);
        return 0;
    endfunction

    task automatic check_field(input string what, input logic [PW-1:0] want,
                               input logic [PW-1:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    // Driver: present queued words, honour gaps and the drain points
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                ops_sent++;
            if (out_valid && !out_stall)
                answers_seen++;
            if (!(in_valid && in_stall)) begin
                if (queued_ops.size() != 0 && !head_loaded) begin
                    gap_left    = queued_ops[0].gap;
                    head_loaded = 1'b1;
                end
                if (queued_ops.size() == 0 || gap_left > 0
                    || (queued_ops[0].drain && ops_sent != answers_seen)) begin
                    if (gap_left > 0)
                        gap_left--;
                    in_valid <= 1'b0;
                end else begin
                    in_valid    <= 1'b1;
                    func        <= queued_ops[0].func;
                    key         <= queued_ops[0].key;
                    payload_in  <= queued_ops[0].payload;
                    hold_pct    <= queued_ops[0].hold_pct;
                    head_loaded = 1'b0;
                    void'(queued_ops.pop_front());
                end
            end
        end
    end

    // Result side back-pressure in bursts of random length
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < hold_pct) begin
            stall_left = $urandom_range(0, 18);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Monitor: predict accepted operations, check accepted results, watch for a hang
    always @(posedge i_clk) begin
        t_table_answer want;
        bit moved;
        if (rst_n) begin
            moved = 1'b0;
            if (in_valid && !in_stall) begin
                apply_table_op(func, key, payload_in);
                moved = 1'b1;
            end
            if (out_valid && !out_stall) begin
                moved = 1'b1;
                if (table_answers.size() == 0) begin
                    errors++;
                    $display("%0t: result word with none expected, found %0b payload %0h count %0d",
                             $time, found, payload_out, entry_count);
                end else begin
                    want = table_answers.pop_front();
                    check_field("found", want.found, found);
                    check_field("payload_out", want.payload, payload_out);
                    check_field("entry_count", want.count, entry_count);
                    check_field("table_full", want.full, table_full);
                    check_field("insert_refused", want.refused, insert_refused);
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("double_hash_table_top regression: fail");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        logic [KW-1:0] pool [POOL_KEYS];
        int homes [3];
        int mode;
        int phase_len;
        int gap_pct;
        int pct;
        int r;
        int i;
        int j;
        bit cluster;
        logic [KW-1:0] k;
        logic [1:0] f;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        func       = dht_pkg::FUNC_RETRIEVE;
        key        = '0;
        payload_in = '0;
        out_stall  = 1'b0;
        for (i = 0; i < SLOTS; i++) begin
            shadow_key[i] = dht_pkg::KEY_EMPTY;
            shadow_pay[i] = '0;
        end
        shadow_count = 0;

        // Directed: key extremes, unknown code, a collision chain with tombstones, duplicates
        queue_op(dht_pkg::FUNC_RETRIEVE, '0, '1, random_gap(30), 10, 1'b0);
        queue_op(dht_pkg::FUNC_INSERT, '0, '1, random_gap(30), 10, 1'b0);
        queue_op(dht_pkg::FUNC_INSERT, '1, '0, random_gap(30), 10, 1'b0);
        queue_op(dht_pkg::FUNC_RETRIEVE, '0, '0, random_gap(30), 10, 1'b0);
        queue_op(dht_pkg::FUNC_RETRIEVE, '1, '1, random_gap(30), 10, 1'b0);
        queue_op(FUNC_NOP, 31'd5, {$urandom, $urandom}, random_gap(30), 10, 1'b0);
        queue_op(dht_pkg::FUNC_INSERT, 31'd5, 64'hA5A5_0000_0000_0005, random_gap(30), 10, 1'b0);
        queue_op(dht_pkg::FUNC_INSERT, 31'd36, 64'h0000_0000_0000_0024, random_gap(30), 10, 1'b0);
        queue_op(dht_pkg::FUNC_INSERT, 31'd67, 64'h8000_0000_0000_0043, random_gap(30), 10, 1'b0);
        queue_op(dht_pkg::FUNC_DELETE, 31'd36, '1, random_gap(30), 10, 1'b0);
        queue_op(dht_pkg::FUNC_RETRIEVE, 31'd67, '0, random_gap(30), 10, 1'b0);
        queue_op(dht_pkg::FUNC_RETRIEVE, 31'd36, '0, random_gap(30), 10, 1'b0);
        queue_op(dht_pkg::FUNC_INSERT, 31'd98, 64'h0123_4567_89AB_CDEF, random_gap(30), 10, 1'b0);
        queue_op(dht_pkg::FUNC_INSERT, 31'd5, 64'hFEDC_BA98_7654_3210, random_gap(30), 10, 1'b0);
        queue_op(dht_pkg::FUNC_RETRIEVE, 31'd5, '0, random_gap(30), 10, 1'b0);
        queue_op(dht_pkg::FUNC_DELETE, 31'd5, '0, random_gap(30), 10, 1'b0);
        queue_op(dht_pkg::FUNC_RETRIEVE, 31'd5, '0, random_gap(30), 10, 1'b0);
        queue_op(dht_pkg::FUNC_DELETE, '0, '0, random_gap(30), 10, 1'b0);
        queue_op(dht_pkg::FUNC_DELETE, '0, '0, random_gap(30), 10, 1'b0);
        queue_op(dht_pkg::FUNC_RETRIEVE, '0, '0, random_gap(30), 10, 1'b0);
        queue_op(dht_pkg::FUNC_DELETE, '1, '0, random_gap(30), 10, 1'b0);
        queue_op(FUNC_NOP, '1, '1, random_gap(30), 10, 1'b0);

        // Random phases: fill, drain or mix over a small key pool; drain the block between phases
        while (queued_ops.size() < RAND_OPS) begin
            mode      = $urandom_range(MODE_FILL, MODE_MIXED);
            phase_len = $urandom_range(60, 160);
            if ($urandom_range(0, 3) == 0) begin
                gap_pct = 0;
                pct     = 0;
            end else begin
                gap_pct = $urandom_range(10, 40);
                pct     = $urandom_range(3, 12);
            end
            cluster = 1'($urandom_range(0, 1));
            for (j = 0; j < 3; j++)
                homes[j] = $urandom_range(0, SLOTS - 1);
            for (j = 0; j < POOL_KEYS; j++) begin
                if (cluster)
                    pool[j] = KW'($urandom_range(0, 69273665) * SLOTS
                                  + homes[$urandom_range(0, 2)]);
                else
                    pool[j] = KW'($urandom);
            end
            if ($urandom_range(0, 7) == 0) begin
                pool[0] = '0;
                pool[1] = '1;
            end
            for (i = 0; i < phase_len; i++) begin
                r = $urandom_range(0, 99);
                case (mode)
                    MODE_FILL:  f = r < 70 ? dht_pkg::FUNC_INSERT : r < 88 ? dht_pkg::FUNC_RETRIEVE :
                                    r < 96 ? dht_pkg::FUNC_DELETE : FUNC_NOP;
                    MODE_DRAIN: f = r < 12 ? dht_pkg::FUNC_INSERT : r < 42 ? dht_pkg::FUNC_RETRIEVE :
                                    r < 96 ? dht_pkg::FUNC_DELETE : FUNC_NOP;
                    default:    f = r < 36 ? dht_pkg::FUNC_INSERT : r < 66 ? dht_pkg::FUNC_RETRIEVE :
                                    r < 96 ? dht_pkg::FUNC_DELETE : FUNC_NOP;
                endcase
                k = ($urandom_range(0, 9) == 0) ? KW'($urandom)
                                                : pool[$urandom_range(0, POOL_KEYS - 1)];
                queue_op(f, k, {$urandom, $urandom}, random_gap(gap_pct), pct, i == 0);
            end
        end

        // Quiet tail: no idling on either side
        for (i = 0; i < TAIL_OPS; i++) begin
            r = $urandom_range(0, 99);
            f = r < 40 ? dht_pkg::FUNC_INSERT : r < 70 ? dht_pkg::FUNC_RETRIEVE :
                r < 97 ? dht_pkg::FUNC_DELETE : FUNC_NOP;
            k = ($urandom_range(0, 3) == 0) ? KW'($urandom) : KW'($urandom_range(0, 47));
            queue_op(f, k, {$urandom, $urandom}, 0, 0, i == 0);
        end

        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        @(posedge i_clk);
        while (queued_ops.size() != 0 || in_valid || table_answers.size() != 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
        if (errors == 0)
            $display("double_hash_table_top regression: pass");
        else
            $display("double_hash_table_top regression: fail");
        $finish;
    end

endmodule
